>>> sv/otu_pkg.sv
package otu_pkg;

  localparam int QUANTITY_BITS = 24;
  localparam int PRICE_BITS    = 32;
  localparam int SYMBOL_BITS   = 64;

  // Message codes
  localparam logic [2:0] CMD_NEW    = 3'd0;
  localparam logic [2:0] CMD_MODIFY = 3'd1;
  localparam logic [2:0] CMD_TRADE  = 3'd2;
  localparam logic [2:0] CMD_CANCEL = 3'd3;
  localparam logic [2:0] CMD_READ   = 3'd4;

  // Result status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_NOMATCH = 3'd1;
  localparam logic [2:0] ST_FULL    = 3'd2;
  localparam logic [2:0] ST_SHORT   = 3'd3;
  localparam logic [2:0] ST_EMPTY   = 3'd4;

  typedef struct packed {
    logic [2:0]               command;
    logic [SYMBOL_BITS-1:0]   symbol_code;
    logic                     side;
    logic [QUANTITY_BITS-1:0] quantity;
    logic [PRICE_BITS-1:0]    price;
    logic [QUANTITY_BITS-1:0] new_quantity;
    logic [PRICE_BITS-1:0]    repl_price;
    logic [5:0]               read_index;
  } otu_in_t;

  typedef struct packed {
    logic [2:0]               status;
    logic [5:0]               entry_index;
    logic [SYMBOL_BITS-1:0]   entry_symbol;
    logic                     entry_side;
    logic [QUANTITY_BITS-1:0] entry_quantity;
    logic [PRICE_BITS-1:0]    entry_price;
    logic [6:0]               entry_count;
  } otu_out_t;

  // Message traveling down the cell chain with its partial result
  typedef struct packed {
    logic     valid;
    logic     done;
    otu_in_t  msg;
    otu_out_t res;
  } otu_pkt_t;

endpackage

>>> sv/otu_cell.sv
module otu_cell import otu_pkg::*; #(
  parameter int IDX = 0,
  parameter int IW  = 6,
  parameter int CW  = 7
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          advance,
  input  logic [IW-1:0] tgt,
  input  logic [CW-1:0] count,
  input  otu_pkt_t      pkt_i,
  output otu_pkt_t      pkt_o
);

  otu_pkt_t                 pkt_r, pkt_nxt;
  logic [SYMBOL_BITS-1:0]   sym_r, sym_nxt;
  logic                     side_r, side_nxt;
  logic [QUANTITY_BITS-1:0] qty_r, qty_nxt;
  logic [PRICE_BITS-1:0]    prc_r, prc_nxt;
  logic                     addr_hit, live, sym_eq, side_eq, prc_eq, qty_eq, hit;
  logic [2:0]               status;

  assign addr_hit = (tgt == IW'(IDX));
  assign live     = (CW'(IDX) < count);
  assign sym_eq   = (sym_r == pkt_i.msg.symbol_code);
  assign side_eq  = (side_r == pkt_i.msg.side);
  assign prc_eq   = (prc_r == pkt_i.msg.price);
  assign qty_eq   = (qty_r == pkt_i.msg.quantity);

  always_comb begin
    pkt_nxt  = pkt_i;
    sym_nxt  = sym_r;
    side_nxt = side_r;
    qty_nxt  = qty_r;
    prc_nxt  = prc_r;
    hit      = 1'b0;
    status   = ST_OK;
    if (pkt_i.valid && !pkt_i.done) begin
      case (pkt_i.msg.command)
        CMD_NEW: begin
          if (addr_hit) begin
            hit      = 1'b1;
            sym_nxt  = pkt_i.msg.symbol_code;
            side_nxt = pkt_i.msg.side;
            qty_nxt  = pkt_i.msg.quantity;
            prc_nxt  = pkt_i.msg.price;
          end
        end
        CMD_READ: begin
          hit = addr_hit;
        end
        CMD_MODIFY: begin
          if (live && sym_eq && side_eq && qty_eq && prc_eq) begin
            hit = 1'b1;
            if (pkt_i.msg.new_quantity != pkt_i.msg.quantity) begin
              qty_nxt = pkt_i.msg.new_quantity;
            end else begin
              prc_nxt = pkt_i.msg.repl_price;
            end
          end
        end
        CMD_TRADE, CMD_CANCEL: begin
          if (live && sym_eq && prc_eq && (side_eq || pkt_i.msg.command == CMD_TRADE)) begin
            hit = 1'b1;
            if (qty_r >= pkt_i.msg.quantity) begin
              qty_nxt = qty_r - pkt_i.msg.quantity;
            end else begin
              status = ST_SHORT;
            end
          end
        end
        default: begin
          hit = 1'b0;
        end
      endcase
    end
    if (hit) begin
      pkt_nxt.done               = 1'b1;
      pkt_nxt.res.status         = status;
      pkt_nxt.res.entry_index    = 6'(IDX);
      pkt_nxt.res.entry_symbol   = sym_nxt;
      pkt_nxt.res.entry_side     = side_nxt;
      pkt_nxt.res.entry_quantity = qty_nxt;
      pkt_nxt.res.entry_price    = prc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pkt_r.valid <= 1'b0;
    end else if (advance) begin
      pkt_r <= pkt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      sym_r  <= sym_nxt;
      side_r <= side_nxt;
      qty_r  <= qty_nxt;
      prc_r  <= prc_nxt;
    end
  end

  assign pkt_o = pkt_r;

endmodule

>>> sv/order_table_update.sv
// Resting-order table built as a chain of TABLE_DEPTH cells, one order per
// cell. Each message (new, modify, trade, cancel, read) enters cell 0 and
// moves one cell per clock while the chain is not held; the first live cell
// that matches (for new and read, the addressed cell) claims it, applies the
// update and fills in the result, and later cells pass it on. One message is
// in flight at a time: it walks the cell chain to the output register, and
// in_ready returns in the same cycle as out_valid, so the next transaction
// starts only once the last has reached the output register. A previous
// result still waiting in the output register holds the chain and delays
// both. A finished result waits in that register while the next
// message is accepted. New orders append at the current count; a full table
// reports status "table full" and changes nothing.
module order_table_update import otu_pkg::*; #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  otu_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output otu_out_t out_data
);

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  logic            busy_r, busy_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [IW-1:0]   tgt_r, tgt_nxt;
  logic            out_valid_r, out_valid_nxt;
  otu_out_t        out_data_r, out_data_nxt;
  otu_pkt_t        launch;
  otu_pkt_t        link [TABLE_DEPTH+1];
  otu_pkt_t        exit_pkt;
  logic [TABLE_DEPTH-1:0] stage_valid;
  logic            in_fire, advance, out_load, full;

  assign in_ready = !busy_r;
  assign in_fire  = in_valid && in_ready;
  assign full     = (count_r == CW'(TABLE_DEPTH));
  assign exit_pkt = link[TABLE_DEPTH];

  // Hold the whole chain only while the last cell holds a result the
  // output register cannot take.
  assign out_load = exit_pkt.valid && (!out_valid_r || out_ready);
  assign advance  = !(exit_pkt.valid && !out_load);

  // Decide up front what needs no search: full table, read past the end,
  // unknown codes.
  always_comb begin
    launch       = '0;
    launch.valid = in_fire;
    launch.msg   = in_data;
    count_nxt    = count_r;
    tgt_nxt      = tgt_r;
    case (in_data.command)
      CMD_NEW: begin
        if (full) begin
          launch.done       = 1'b1;
          launch.res.status = ST_FULL;
        end else begin
          tgt_nxt = IW'(count_r);
          if (in_fire) begin
            count_nxt = count_r + CW'(1);
          end
        end
      end
      CMD_READ: begin
        if (32'(in_data.read_index) < 32'(count_r)) begin
          tgt_nxt = IW'(in_data.read_index);
        end else begin
          launch.done            = 1'b1;
          launch.res.status      = ST_EMPTY;
          launch.res.entry_index = in_data.read_index;
        end
      end
      CMD_MODIFY, CMD_TRADE, CMD_CANCEL: begin
        launch.done = 1'b0;
      end
      default: begin
        launch.done       = 1'b1;
        launch.res.status = ST_NOMATCH;
      end
    endcase
    if (!in_fire) begin
      tgt_nxt = tgt_r;
    end
  end

  assign link[0] = launch;

  // Cell 0 sees the message in its accepting cycle, before tgt_r loads, so
  // feed the chain the target as it will be; it equals tgt_r otherwise.
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    otu_cell #(
      .IDX (i),
      .IW  (IW),
      .CW  (CW)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .advance (advance),
      .tgt     (tgt_nxt),
      .count   (count_r),
      .pkt_i   (link[i]),
      .pkt_o   (link[i+1])
    );
    assign stage_valid[i] = link[i+1].valid;
  end

  // A search that ran off the end of the chain found nothing.
  always_comb begin
    out_data_nxt = out_data_r;
    out_valid_nxt = out_valid_r;
    busy_nxt = busy_r;
    if (in_fire) begin
      busy_nxt = 1'b1;
    end
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
      busy_nxt      = 1'b0;
      if (exit_pkt.done) begin
        out_data_nxt = exit_pkt.res;
      end else begin
        out_data_nxt        = '0;
        out_data_nxt.status = ST_NOMATCH;
      end
      out_data_nxt.entry_count = 7'(count_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tgt_r      <= tgt_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(stage_valid))
    else $error("more than one message in the cell chain");

  a_idle_chain_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> (stage_valid == '0))
    else $error("cell chain holds a message while idle");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(TABLE_DEPTH))
    else $error("order count exceeds table depth");

  a_append_counts: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_data.command == CMD_NEW && !full |=> count_r == $past(count_r) + CW'(1))
    else $error("append did not advance the order count");

  a_busy_until_result: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && !out_load |=> busy_r)
    else $error("block went idle without delivering a result");

endmodule

>>> tb/sv/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import otu_pkg::*;

  // Geometry of the block under test, plus run shaping.
  localparam int BOOK_DEPTH      = 64;
  localparam int RANDOM_ITEMS    = 1800;
  // Long enough for one message to walk the whole cell chain.
  localparam int DRAIN_CYCLES    = BOOK_DEPTH + 16;
  // Longest quiet stretch: chain walk, a full hold-off and the idle draws.
  localparam int STALL_LIMIT     = 2000;
  localparam int SENDER_PAUSE_AT = 1000;
  localparam int HOLD_OFF_AT     = 400;
  localparam int HOLD_OFF_CYCLES = 250;

  // Command codes the package leaves unnamed; the block treats them as no-ops.
  localparam logic [2:0] CMD_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] CMD_UNUSED_LAST  = 3'd7;

  localparam logic [SYMBOL_BITS-1:0] SYM_AAPL = SYMBOL_BITS'("AAPL");
  localparam logic [SYMBOL_BITS-1:0] SYM_MSFT = SYMBOL_BITS'("MSFT");

  typedef struct packed {
    otu_in_t  msg;
    logic     typed;
    otu_out_t want;
  } drill_row_t;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  otu_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  otu_out_t out_data;

  // Shadow copy of the order table, advanced once per accepted transaction.
  logic [SYMBOL_BITS-1:0]   book_symbol   [BOOK_DEPTH];
  logic                     book_side     [BOOK_DEPTH];
  logic [QUANTITY_BITS-1:0] book_quantity [BOOK_DEPTH];
  logic [PRICE_BITS-1:0]    book_price    [BOOK_DEPTH];
  int                       book_count = 0;

  // Results owed by the block, oldest first.
  otu_out_t awaited_results [$];
  int       mismatch_count = 0;
  int       results_seen   = 0;

  // Directed stimulus, walked in order.
  drill_row_t drill_rows [$];

  // A few symbols and prices reused on purpose so that searches collide and
  // first-match ordering actually matters.
  logic [SYMBOL_BITS-1:0] ticker_pool [4] = '{SYM_AAPL, SYM_MSFT, SYMBOL_BITS'("IBM"),
                                              SYMBOL_BITS'("BRK.A")};
  logic [PRICE_BITS-1:0]  price_pool  [4] = '{32'd1500, 32'd1501, 32'd20000, 32'hFFFF_FFFF};

  order_table_update #(
    .TABLE_DEPTH(BOOK_DEPTH)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic void add_drill(input drill_row_t row);
    drill_rows.insert(drill_rows.size(), row);
  endfunction

  // Apply one message to the shadow table and return the result it owes.
  function automatic otu_out_t apply_to_book(input otu_in_t m);
    otu_out_t r;
    int       hit;
    r = '0;
    r.status = ST_OK;
    hit = -1;
    case (m.command)
      CMD_NEW: begin
        if (book_count >= BOOK_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          book_symbol[book_count]   = m.symbol_code;
          book_side[book_count]     = m.side;
          book_quantity[book_count] = m.quantity;
          book_price[book_count]    = m.price;
          hit = book_count;
          book_count++;
        end
      end
      CMD_MODIFY, CMD_TRADE, CMD_CANCEL: begin
        // First live entry in insertion order wins; trade ignores side,
        // only modify looks at the quantity.
        for (int i = 0; i < book_count; i++) begin
          if (hit < 0 && book_symbol[i] == m.symbol_code && book_price[i] == m.price &&
              (m.command == CMD_TRADE || book_side[i] == m.side) &&
              (m.command != CMD_MODIFY || book_quantity[i] == m.quantity)) begin
            hit = i;
          end
        end
        if (hit < 0) begin
          r.status = ST_NOMATCH;
        end else if (m.command == CMD_MODIFY) begin
          if (m.new_quantity != m.quantity) book_quantity[hit] = m.new_quantity;
          else book_price[hit] = m.repl_price;
        end else if (book_quantity[hit] >= m.quantity) begin
          book_quantity[hit] = book_quantity[hit] - m.quantity;
        end else begin
          r.status = ST_SHORT;
        end
      end
      CMD_READ: begin
        if (int'(m.read_index) < book_count) begin
          hit = int'(m.read_index);
        end else begin
          r.status = ST_EMPTY;
          r.entry_index = m.read_index;
        end
      end
      default: begin
        r.status = ST_NOMATCH;
      end
    endcase
    if (hit >= 0) begin
      r.entry_index    = 6'(hit);
      r.entry_symbol   = book_symbol[hit];
      r.entry_side     = book_side[hit];
      r.entry_quantity = book_quantity[hit];
      r.entry_price    = book_price[hit];
    end
    r.entry_count = 7'(book_count);
    return r;
  endfunction

  // Draw one market message. Most searches copy a live entry so they land,
  // some are nudged off by one field, the rest are noise. Every field starts
  // out fully random so that the fields a command ignores still toggle.
  function automatic otu_in_t draw_market_message();
    otu_in_t                  m;
    logic [191:0]             noise;
    int                       roll;
    int                       new_share;
    int                       span;
    int                       slot;
    logic [QUANTITY_BITS-1:0] held;
    noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    m = noise[$bits(otu_in_t)-1:0];
    // Keep some new orders flowing once full so the full flag keeps firing.
    new_share = (book_count < BOOK_DEPTH) ? 30 : 8;
    span = (78 - new_share) / 3;
    roll = $urandom_range(99, 0);
    if (roll < new_share) begin
      m.command = CMD_NEW;
      if ($urandom_range(3, 0) != 0) m.symbol_code = ticker_pool[$urandom_range(3, 0)];
      if ($urandom_range(4, 0) < 3) m.price = price_pool[$urandom_range(3, 0)];
      if ($urandom_range(1, 0) == 0) m.quantity = QUANTITY_BITS'($urandom_range(1000, 0));
      return m;
    end
    if (roll >= 95) begin
      m.command = 3'($urandom_range(CMD_UNUSED_LAST, CMD_UNUSED_FIRST));
      return m;
    end
    if (roll >= 78) begin
      m.command = CMD_READ;
      return m;
    end
    if (roll < new_share + span) m.command = CMD_MODIFY;
    else if (roll < new_share + 2 * span) m.command = CMD_TRADE;
    else m.command = CMD_CANCEL;

    if (book_count > 0 && $urandom_range(9, 0) < 8) begin
      slot = $urandom_range(book_count - 1, 0);
      held = book_quantity[slot];
      m.symbol_code = book_symbol[slot];
      m.side        = book_side[slot];
      m.price       = book_price[slot];
      if (m.command == CMD_MODIFY) begin
        m.quantity = held;
        // Equal quantities select a price change; a fresh small quantity
        // also refills entries drained by trades.
        if ($urandom_range(1, 0) == 0) m.new_quantity = held;
        else if ($urandom_range(1, 0) == 0)
          m.new_quantity = QUANTITY_BITS'($urandom_range(1000, 0));
      end else begin
        case ($urandom_range(3, 0))
          0: m.quantity = held;
          1: m.quantity = QUANTITY_BITS'($urandom_range(held, 0));
          2: m.quantity = held + 1'b1;
          default: ;
        endcase
      end
      // Break the match now and then.
      if ($urandom_range(7, 0) == 0) begin
        if ($urandom_range(1, 0) == 0) m.price = m.price ^ 1'b1;
        else m.side = ~m.side;
      end
    end else begin
      if ($urandom_range(1, 0) == 0) m.symbol_code = ticker_pool[$urandom_range(3, 0)];
      if ($urandom_range(1, 0) == 0) m.price = price_pool[$urandom_range(3, 0)];
    end
    return m;
  endfunction

  function automatic otu_in_t message_of(input logic [2:0] cmd,
                                         input logic [SYMBOL_BITS-1:0] sym,
                                         input logic sd,
                                         input logic [QUANTITY_BITS-1:0] qty,
                                         input logic [PRICE_BITS-1:0] prc,
                                         input logic [QUANTITY_BITS-1:0] nqty,
                                         input logic [PRICE_BITS-1:0] nprc,
                                         input logic [5:0] ridx);
    otu_in_t m;
    m.command      = cmd;
    m.symbol_code  = sym;
    m.side         = sd;
    m.quantity     = qty;
    m.price        = prc;
    m.new_quantity = nqty;
    m.repl_price   = nprc;
    m.read_index   = ridx;
    return m;
  endfunction

  function automatic otu_out_t outcome_of(input logic [2:0] st, input logic [5:0] idx,
                                          input logic [SYMBOL_BITS-1:0] sym,
                                          input logic sd,
                                          input logic [QUANTITY_BITS-1:0] qty,
                                          input logic [PRICE_BITS-1:0] prc,
                                          input logic [6:0] cnt);
    otu_out_t r;
    r.status         = st;
    r.entry_index    = idx;
    r.entry_symbol   = sym;
    r.entry_side     = sd;
    r.entry_quantity = qty;
    r.entry_price    = prc;
    r.entry_count    = cnt;
    return r;
  endfunction

  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatch_count++;
    $display("ERROR %0t ns, result %0d: %s = 0x%0h, expected 0x%0h",
             $time, results_seen, field, got, want);
  endtask

  task automatic check_result(input otu_out_t got);
    otu_out_t want;
    results_seen++;
    if (awaited_results.size() == 0) begin
      report_mismatch("unexpected transaction, status", 64'(got.status), '0);
      return;
    end
    want = awaited_results.pop_front();
    if (got.status != want.status)
      report_mismatch("status", 64'(got.status), 64'(want.status));
    if (got.entry_index != want.entry_index)
      report_mismatch("entry_index", 64'(got.entry_index), 64'(want.entry_index));
    if (got.entry_symbol != want.entry_symbol)
      report_mismatch("entry_symbol", got.entry_symbol, want.entry_symbol);
    if (got.entry_side != want.entry_side)
      report_mismatch("entry_side", 64'(got.entry_side), 64'(want.entry_side));
    if (got.entry_quantity != want.entry_quantity)
      report_mismatch("entry_quantity", 64'(got.entry_quantity), 64'(want.entry_quantity));
    if (got.entry_price != want.entry_price)
      report_mismatch("entry_price", 64'(got.entry_price), 64'(want.entry_price));
    if (got.entry_count != want.entry_count)
      report_mismatch("entry_count", 64'(got.entry_count), 64'(want.entry_count));
  endtask

  // Offer one transaction after a random gap, hold it until taken, then
  // record what it owes. A typed row supplies its own expectation, but the
  // shadow table still advances so later rows see the right state.
  task automatic send_message(input otu_in_t msg, input logic typed, input otu_out_t want,
                              input int serial);
    int       gap;
    otu_out_t predicted;
    // Every fourth stretch of 200 transactions runs back to back.
    gap = (((serial / 200) % 4) != 3) ? $urandom_range(9, 0) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= msg;
    do @(posedge clk); while (!in_ready);
    predicted = apply_to_book(msg);
    awaited_results.insert(awaited_results.size(), typed ? want : predicted);
  endtask

  // Result side: random back-pressure per transaction, one long hold-off so
  // the block fills and stalls its input, and stretches with none at all.
  initial begin : result_sink
    int gap;
    while (!rst_n) @(posedge clk);
    forever begin
      if (results_seen == HOLD_OFF_AT) gap = HOLD_OFF_CYCLES;
      else gap = (((results_seen / 170) % 4) != 1) ? $urandom_range(9, 0) : 0;
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      check_result(out_data);
    end
  end

  // End the run if neither channel moves a transaction for too long.
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("order_table_update: timeout after %0d quiet cycles", STALL_LIMIT);
    $display("order_table_update: mismatch");
    $finish;
  end

  initial begin : stimulus
    otu_in_t    msg;
    int         serial;

    // Empty table: reads past the end, a search with nothing to find, and
    // the unused command codes all leave zeros behind, bar the echoed read index.
    add_drill('{message_of(CMD_READ, '0, 1'b0, '0, '0, '0, '0, 6'd0), 1'b1,
                outcome_of(ST_EMPTY, 6'd0, '0, 1'b0, '0, '0, 7'd0)});
    add_drill('{message_of(CMD_READ, '1, 1'b1, '1, '1, '1, '1, 6'd63), 1'b1,
                outcome_of(ST_EMPTY, 6'd63, '0, 1'b0, '0, '0, 7'd0)});
    add_drill('{message_of(CMD_MODIFY, '1, 1'b1, '1, '1, 24'd5, '1, '1), 1'b1,
                outcome_of(ST_NOMATCH, '0, '0, 1'b0, '0, '0, 7'd0)});
    add_drill('{message_of(CMD_UNUSED_FIRST, '0, 1'b0, '0, '0, '0, '0, '0), 1'b1,
                outcome_of(ST_NOMATCH, '0, '0, 1'b0, '0, '0, 7'd0)});
    add_drill('{message_of(CMD_UNUSED_LAST, '1, 1'b1, '1, '1, '1, '1, '1), 1'b1,
                outcome_of(ST_NOMATCH, '0, '0, 1'b0, '0, '0, 7'd0)});
    // Field extremes on append, then two identical orders to test first-match.
    add_drill('{message_of(CMD_NEW, '1, 1'b1, '1, '1, '0, '0, '0), 1'b1,
                outcome_of(ST_OK, 6'd0, '1, 1'b1, '1, '1, 7'd1)});
    add_drill('{message_of(CMD_NEW, '0, 1'b0, '0, '0, '1, '1, '1), 1'b1,
                outcome_of(ST_OK, 6'd1, '0, 1'b0, '0, '0, 7'd2)});
    add_drill('{message_of(CMD_NEW, SYM_AAPL, 1'b0, 24'd100, 32'd1500, '0, '0, '0),
                1'b1, outcome_of(ST_OK, 6'd2, SYM_AAPL, 1'b0, 24'd100, 32'd1500, 7'd3)});
    add_drill('{message_of(CMD_NEW, SYM_AAPL, 1'b0, 24'd100, 32'd1500, '0, '0, '0),
                1'b1, outcome_of(ST_OK, 6'd3, SYM_AAPL, 1'b0, 24'd100, 32'd1500, 7'd4)});
    add_drill('{message_of(CMD_NEW, SYM_MSFT, 1'b1, 24'd50, 32'd1500, '0, '0, '0),
                1'b0, '0});
    // Trade ignores side; then one too large for the remaining quantity.
    add_drill('{message_of(CMD_TRADE, SYM_AAPL, 1'b1, 24'd40, 32'd1500, '0, '0, '0),
                1'b0, '0});
    add_drill('{message_of(CMD_TRADE, SYM_AAPL, 1'b0, 24'd200, 32'd1500, '0, '0, '0),
                1'b0, '0});
    // Cancel needs the side; the second one drains the entry to zero.
    add_drill('{message_of(CMD_CANCEL, SYM_AAPL, 1'b1, 24'd10, 32'd1500, '0, '0, '0),
                1'b0, '0});
    add_drill('{message_of(CMD_CANCEL, SYM_AAPL, 1'b0, 24'd60, 32'd1500, '0, '0, '0),
                1'b0, '0});
    // Modify with an unchanged quantity moves the price, otherwise the quantity.
    add_drill('{message_of(CMD_MODIFY, SYM_AAPL, 1'b0, 24'd0, 32'd1500, 24'd0,
                           32'd1600, '0), 1'b0, '0});
    add_drill('{message_of(CMD_MODIFY, SYM_AAPL, 1'b0, 24'd100, 32'd1500, 24'd250,
                           32'd1, '0), 1'b0, '0});
    // Exact-quantity trades at both extremes, then a cancel left short.
    add_drill('{message_of(CMD_TRADE, '1, 1'b0, '1, '1, '0, '0, '0), 1'b0, '0});
    add_drill('{message_of(CMD_TRADE, '0, 1'b1, '0, '0, '1, '1, '1), 1'b0, '0});
    add_drill('{message_of(CMD_CANCEL, '1, 1'b1, 24'd1, '1, '0, '0, '0), 1'b0, '0});
    add_drill('{message_of(CMD_READ, '0, 1'b0, '0, '0, '0, '0, 6'd4), 1'b0, '0});
    add_drill('{message_of(CMD_READ, '0, 1'b0, '0, '0, '0, '0, 6'd5), 1'b1,
                outcome_of(ST_EMPTY, 6'd5, '0, 1'b0, '0, '0, 7'd5)});

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    serial = 0;
    foreach (drill_rows[k]) begin
      send_message(drill_rows[k].msg, drill_rows[k].typed, drill_rows[k].want, serial);
      serial++;
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // Drop valid once and hold off until the block has returned everything.
      if (n == SENDER_PAUSE_AT) begin
        in_valid <= 1'b0;
        do @(posedge clk); while (awaited_results.size() != 0);
      end
      msg = draw_market_message();
      send_message(msg, 1'b0, '0, serial);
      serial++;
    end

    // Drain: wait for every owed result, then one chain walk more for strays.
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("order_table_update: match");
    end else begin
      $display("order_table_update: mismatch");
    end
    $finish;
  end

endmodule
